// ----- sv/asort_pkg.sv -----
`default_nettype none
package asort_pkg;
   localparam int DefaultSize = 16;
   localparam int ValueWidth  = 32;

   // input word
   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic                         last;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [ValueWidth-1:0] sorted_value;
      logic                         last_out;
      logic                         overflow;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // store incoming word
      logic cmp;      // compare/swap step at pointer
      logic emit;     // emit marker; not used by the datapath
      logic clear;    // end of set
   } dp_cmd_type;
endpackage
`default_nettype wire

// ----- sv/asort_if.sv -----
`default_nettype none
interface asort_req_if
   import asort_pkg::*;
   (input wire logic clock);
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface asort_rsp_if
   import asort_pkg::*;
   (input wire logic clock);
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/asort_datapath.sv -----
`default_nettype none
module asort_datapath
   import asort_pkg::*;
#(
   parameter int SIZE = DefaultSize,
   localparam int IdxW = (SIZE > 1) ? $clog2(SIZE) : 1,
   localparam int CntW = $clog2(SIZE + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dp_cmd_type                   cmd,
   input  wire logic [IdxW-1:0]              ptr,
   input  wire logic signed [ValueWidth-1:0] in_value,
   output logic [CntW-1:0]                   count,
   output logic                              dropped,
   output logic signed [ValueWidth-1:0]      out_value,
   output logic                              swapped
);
   // element store: one compare/swap step per cycle on a neighbor pair
   logic signed [ValueWidth-1:0] store_ff [SIZE];
   logic [CntW-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;

   logic [IdxW-1:0] ptr_nx;
   assign ptr_nx  = ptr + IdxW'(1);
   assign swapped = store_ff[ptr] > store_ff[ptr_nx];

   // count and drop flag
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.load) begin
         if (count_ff < CntW'(SIZE)) count_in = count_ff + CntW'(1);
         else dropped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // store writes: load, or neighbor swap (bubble pass)
   always_ff @(posedge clock) begin
      if (cmd.load && count_ff < CntW'(SIZE)) begin
         store_ff[count_ff[IdxW-1:0]] <= in_value;
      end else if (cmd.cmp && swapped) begin
         store_ff[ptr]    <= store_ff[ptr_nx];
         store_ff[ptr_nx] <= store_ff[ptr];
      end
   end

   assign count     = count_ff;
   assign dropped   = dropped_ff;
   assign out_value = store_ff[ptr];
endmodule
`default_nettype wire

// ----- sv/asort_ctrl.sv -----
`default_nettype none
module asort_ctrl
   import asort_pkg::*;
#(
   parameter int SIZE = DefaultSize,
   localparam int IdxW = (SIZE > 1) ? $clog2(SIZE) : 1,
   localparam int CntW = $clog2(SIZE + 1)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic                 rsp_last,
   output dp_cmd_type           cmd,
   output logic [IdxW-1:0]      ptr,
   input  wire logic [CntW-1:0] count,
   input  wire logic            swapped
);
   localparam logic [1:0] StLoad = 2'd0;
   localparam logic [1:0] StSort = 2'd1;
   localparam logic [1:0] StEmit = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [IdxW-1:0] ptr_ff, ptr_in;
   logic            any_ff, any_in;   // a swap happened this pass
   logic [CntW-1:0] n;

   // n = stored count after final load (count already settled in SORT/EMIT)
   assign n = count;

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      any_in    = any_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      unique case (state_ff)
         StLoad: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = StSort;
                  ptr_in   = '0;
                  any_in   = 1'b0;
               end
            end
         end
         StSort: begin
            // pairs ptr,ptr+1 for ptr < n-1
            if ((CntW+1)'(ptr_ff) + (CntW+1)'(2) > (CntW+1)'(n)) begin
               ptr_in = '0;
               any_in = 1'b0;
               if (!any_ff) state_in = StEmit;
            end else begin
               cmd.cmp = 1'b1;
               ptr_in  = ptr_ff + IdxW'(1);
               if (swapped) any_in = 1'b1;
            end
         end
         StEmit: begin
            rsp_valid = 1'b1;
            rsp_last  = ((CntW+1)'(ptr_ff) + (CntW+1)'(1)) == (CntW+1)'(n);
            if (rsp_ready) begin
               ptr_in = ptr_ff + IdxW'(1);
               if (rsp_last) begin
                  cmd.clear = 1'b1;
                  state_in  = StLoad;
                  ptr_in    = '0;
               end
            end
         end
         default: state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         ptr_ff   <= '0;
         any_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         any_ff   <= any_in;
      end
   end

   assign ptr = ptr_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input and output active together");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count != '0) else $error("emit with empty store");
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.cmp, cmd.emit, cmd.clear}))
      else $error("conflicting datapath commands");
endmodule
`default_nettype wire

// ----- sv/array_sorter_unit.sv -----
// array_sorter_unit: collects a set of signed 32-bit words and returns them
// in ascending order.
// req channel: one word per element, value plus last mark. Words are taken
// one per cycle while the unit is loading. Elements past SIZE are dropped and
// overflow is raised on every result word of that set.
// After the word marked last, the unit sorts in place with a bubble pass
// engine, one neighbor compare/swap per cycle over the store register file;
// each pass walks the neighbor pairs once, at most n passes, until a pass
// makes no swap. req_ready is low meanwhile.
// rsp channel: n result words in ascending order, last_out on the final one,
// one per cycle while rsp_ready is high. A stalled receiver holds the current
// word stable; no new input is taken until the whole set is delivered.
// Reset (synchronous, active high) empties the store and returns to loading.
`default_nettype none
module array_sorter_unit
   import asort_pkg::*;
#(
   parameter int SIZE = DefaultSize
) (
   input wire logic   clock,
   input wire logic   reset,
   asort_req_if.sink  req,
   asort_rsp_if.source rsp
);
   localparam int IdxW = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int CntW = $clog2(SIZE + 1);

   dp_cmd_type      cmd;
   logic [IdxW-1:0] ptr;
   logic [CntW-1:0] count;
   logic            dropped, swapped, last_out;
   logic signed [ValueWidth-1:0] out_value;

   asort_ctrl #(.SIZE(SIZE)) u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_last (req.data.last), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_last (last_out),
      .cmd, .ptr, .count, .swapped
   );

   asort_datapath #(.SIZE(SIZE)) u_dp (
      .clock, .reset, .cmd, .ptr,
      .in_value (req.data.value),
      .count, .dropped, .out_value, .swapped
   );

   assign rsp.data.sorted_value = out_value;
   assign rsp.data.last_out     = last_out;
   assign rsp.data.overflow     = dropped;
endmodule
`default_nettype wire
